FILE: design/hbm_pkg.sv
`timescale 1ns / 1ps
package hbm_pkg;

  // Node table size and the widest node index it may need
  localparam int NODES_DEF   = 16;
  localparam int NODE_W_MAX  = 6;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Heartbeat identifier base
  localparam logic [10:0] HB_BASE_ID = 11'h700;

  // Input request kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // Result kinds
  localparam logic RES_HEARTBEAT = 1'b0;
  localparam logic RES_TIMEOUT   = 1'b1;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_NODE_ID    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEND_INTERVAL  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OPERATING_MODE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_PERIOD   = 3'd4;

  // Configuration reset values
  localparam logic [6:0]  RST_OWN_NODE_ID    = 7'd1;
  localparam logic [15:0] RST_SEND_INTERVAL  = 16'd1000;
  localparam logic [7:0]  RST_OPERATING_MODE = 8'd0;
  localparam logic [15:0] RST_TIMEOUT        = 16'd1500;
  localparam logic [15:0] RST_CHECK_PERIOD   = 16'd1000;

  typedef struct packed {
    logic [6:0]  own_node_id;
    logic [15:0] send_interval_ms;
    logic [7:0]  operating_mode;
    logic [15:0] timeout_ms;
    logic [15:0] check_period_ms;
  } hbm_cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                  is_tick;
    logic [NODE_W_MAX-1:0] node;
  } hbm_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] tx_id;
    logic [7:0]  tx_byte;
    logic [3:0]  node_index;
    logic        last;
  } hbm_result_t;

endpackage

FILE: design/hbm_front.sv
`timescale 1ns / 1ps
module hbm_front
  import hbm_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_length,
  input  logic        q_ready,
  output logic        q_push,
  output hbm_cmd_t    q_cmd
);

  logic [10:0] id_off;
  logic        frame_hit;

  // Classify: heartbeat frames of known nodes with data, everything else dropped
  assign id_off    = frame_id - HB_BASE_ID;
  assign frame_hit = (frame_id >= HB_BASE_ID) && (id_off < 11'(NODES)) &&
                     (frame_length != 4'd0);

  // Accept whenever the queue has room; drop foreign frames on the floor
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && ((in_op == OP_TICK) || frame_hit);

  always_comb begin
    q_cmd.is_tick = (in_op == OP_TICK);
    q_cmd.node    = (in_op == OP_TICK) ? '0 : id_off[NODE_W_MAX-1:0];
  end

endmodule

FILE: design/hbm_queue.sv
`timescale 1ns / 1ps
module hbm_queue
  import hbm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hbm_cmd_t push_cmd,
  output logic     push_ready,
  input  logic     pop,
  output hbm_cmd_t pop_cmd,
  output logic     pop_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbm_cmd_t           slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/hbm_back.sv
`timescale 1ns / 1ps
module hbm_back
  import hbm_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hbm_cfg_t    cfg,
  input  logic        pop_valid,
  input  hbm_cmd_t    pop_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output hbm_result_t out_res
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECIDE    = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_SCAN_LAST = 3'd3;
  localparam logic [2:0] S_HB        = 3'd4;
  localparam logic [2:0] S_WALK      = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [31:0]      last_send_r, last_send_nxt;
  logic [31:0]      last_scan_r, last_scan_nxt;
  logic [NODES-1:0] seen_r, seen_nxt;
  logic [NODES-1:0] mask_r, mask_nxt;
  logic             hb_r, hb_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] walk_idx_r, walk_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  hbm_result_t      out_res_r, out_res_nxt;

  logic [31:0]      seen_at_mem [NODES];
  logic [31:0]      rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;

  logic             slot_free;
  logic             load;
  hbm_result_t      load_res;
  logic [31:0]      silent_ms;
  logic             hit;
  logic [NODES-1:0] hit_bit;
  logic [NODES-1:0] mask_upd;
  logic [NODES-1:0] walk_bit;
  logic [NODES-1:0] mask_clr;

  assign wr_idx    = pop_cmd.node[IDX_W-1:0];
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Node timestamp table: written by frames, read one entry a cycle by the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_at_mem[wr_idx] <= now_r;
    end
    rd_data_r <= seen_at_mem[scan_idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    last_send_nxt = last_send_r;
    last_scan_nxt = last_scan_r;
    seen_nxt      = seen_r;
    hb_nxt        = hb_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = scan_idx_r;
    walk_idx_nxt  = walk_idx_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    load          = 1'b0;
    load_res      = '0;

    // Compare the entry read last cycle against the timeout
    silent_ms = now_r - rd_data_r;
    hit       = cmp_vld_r && seen_r[cmp_idx_r] && (silent_ms > {16'd0, cfg.timeout_ms});
    hit_bit   = '0;
    hit_bit[cmp_idx_r] = hit;
    mask_upd  = mask_r | hit_bit;
    mask_nxt  = mask_upd;

    walk_bit  = '0;
    walk_bit[walk_idx_r] = 1'b1;
    mask_clr  = mask_r & ~walk_bit;

    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          pop = 1'b1;
          if (pop_cmd.is_tick) begin
            now_nxt   = now_r + 32'd1;
            state_nxt = S_DECIDE;
          end else begin
            mem_we           = 1'b1;
            seen_nxt[wr_idx] = 1'b1;
          end
        end
      end

      // Decide whether a heartbeat and a scan are due
      S_DECIDE: begin
        mask_nxt = '0;
        hb_nxt   = (now_r - last_send_r) >= {16'd0, cfg.send_interval_ms};
        if (hb_nxt) begin
          last_send_nxt = now_r;
        end
        if ((now_r - last_scan_r) >= {16'd0, cfg.check_period_ms}) begin
          last_scan_nxt = now_r;
          scan_idx_nxt  = '0;
          state_nxt     = S_SCAN;
        end else if (hb_nxt) begin
          state_nxt = S_HB;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Issue one table read a cycle
      S_SCAN: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_idx_r;
        if (scan_idx_r == IDX_W'(NODES - 1)) begin
          state_nxt = S_SCAN_LAST;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      // Last compare lands here
      S_SCAN_LAST: begin
        walk_idx_nxt = '0;
        if (hb_r) begin
          state_nxt = S_HB;
        end else if (mask_upd != '0) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_HB: begin
        if (slot_free) begin
          load                = 1'b1;
          load_res.kind       = RES_HEARTBEAT;
          load_res.tx_id      = HB_BASE_ID + {4'd0, cfg.own_node_id};
          load_res.tx_byte    = cfg.operating_mode;
          load_res.node_index = 4'd0;
          load_res.last       = (mask_r == '0);
          walk_idx_nxt        = '0;
          state_nxt           = (mask_r != '0) ? S_WALK : S_IDLE;
        end
      end

      // Emit timed-out nodes in ascending order
      S_WALK: begin
        if (mask_r[walk_idx_r]) begin
          if (slot_free) begin
            load                = 1'b1;
            load_res.kind       = RES_TIMEOUT;
            load_res.node_index = 4'(walk_idx_r);
            load_res.last       = (mask_clr == '0);
            mask_nxt            = mask_clr;
            if (mask_clr == '0) begin
              state_nxt = S_IDLE;
            end else begin
              walk_idx_nxt = walk_idx_r + 1'b1;
            end
          end
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load a new result or drain the taken one
    out_res_nxt = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = load_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      last_send_r <= '0;
      last_scan_r <= '0;
      seen_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      last_send_r <= last_send_nxt;
      last_scan_r <= last_scan_nxt;
      seen_r      <= seen_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers, set before use in each tick
  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    hb_r       <= hb_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    walk_idx_r <= walk_idx_nxt;
    out_res_r  <= out_res_nxt;
  end

endmodule

FILE: design/can_heartbeat_monitor_core.sv
`timescale 1ns / 1ps
// Heartbeat producer and consumer for a CAN node. Each input request is either a
// one-millisecond tick or a received frame; frames with identifier 0x700 + n
// (n below NODES) and a nonzero length record the current time for node n, and
// all other frames are dropped. On a tick the time advances, a heartbeat frame
// (0x700 + own node id, carrying the operating mode) is emitted once the send
// interval has passed, and once per check period the node table is scanned and
// a timeout result is emitted for every heard-from node silent longer than the
// timeout, heartbeat first, then nodes in ascending order; tlast marks the last
// result of a tick. A small queue sits between the input side and the engine.
// A frame occupies the engine in its idle state only; a tick goes through the decide
// state, then, if a scan is due, the scan (one table read per cycle through the
// single read port) and the last-compare state, then the heartbeat state if one is
// due, and the walk up to the last timed-out node; the result register can stall it.
module can_heartbeat_monitor_core
  import hbm_pkg::*;
#(
  parameter int NODES       = NODES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // frame_id[10:0], frame_length[14:11],
                                            // frame_byte0[22:15], zero pad[23]
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // tx_id[10:0], tx_byte[18:11],
                                            // node_index[22:19], zero pad[23]
  output logic                  out_tuser,  // result_kind
  output logic                  out_tlast   // last_of_run
);

  hbm_cfg_t    cfg_r;
  logic        q_push, q_ready, q_pop, q_valid;
  hbm_cmd_t    q_in_cmd, q_out_cmd;
  hbm_result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id      <= RST_OWN_NODE_ID;
      cfg_r.send_interval_ms <= RST_SEND_INTERVAL;
      cfg_r.operating_mode   <= RST_OPERATING_MODE;
      cfg_r.timeout_ms       <= RST_TIMEOUT;
      cfg_r.check_period_ms  <= RST_CHECK_PERIOD;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_OWN_NODE_ID:    cfg_r.own_node_id      <= cfg_wdata[6:0];
        CFG_SEND_INTERVAL:  cfg_r.send_interval_ms <= cfg_wdata;
        CFG_OPERATING_MODE: cfg_r.operating_mode   <= cfg_wdata[7:0];
        CFG_TIMEOUT:        cfg_r.timeout_ms       <= cfg_wdata;
        CFG_CHECK_PERIOD:   cfg_r.check_period_ms  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hbm_front #(
    .NODES (NODES)
  ) u_front (
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .frame_id     (in_tdata[10:0]),
    .frame_length (in_tdata[14:11]),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd)
  );

  hbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_cmd    (q_out_cmd),
    .pop_valid  (q_valid)
  );

  hbm_back #(
    .NODES (NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_valid),
    .pop_cmd   (q_out_cmd),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {1'b0, res.node_index, res.tx_byte, res.tx_id};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // Reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Timeout results carry no heartbeat identifier or mode byte
  a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RES_TIMEOUT)) |-> (out_tdata[18:0] == 19'd0))
    else $error("timeout result with heartbeat fields set");

  // Heartbeat results carry an identifier in the heartbeat range and node 0
  a_heartbeat_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RES_HEARTBEAT)) |->
      ((out_tdata[10:7] == 4'b1110) && (out_tdata[22:19] == 4'd0)))
    else $error("heartbeat result with bad identifier or node index");

endmodule
